[sv/cpu8_pkg.sv]
// Shared types and operation codes for the 8-bit execute unit.
package cpu8_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
    OP_EOR = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
    OP_BIT = 6'd8,  OP_LDA = 6'd9,  OP_LDX = 6'd10, OP_LDY = 6'd11,
    OP_ASL = 6'd12, OP_LSR = 6'd13, OP_ROL = 6'd14, OP_ROR = 6'd15,
    OP_INC = 6'd16, OP_DEC = 6'd17, OP_INX = 6'd18, OP_INY = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23,
    OP_TXA = 6'd24, OP_TYA = 6'd25, OP_TSX = 6'd26, OP_TXS = 6'd27,
    OP_CLC = 6'd28, OP_CLD = 6'd29, OP_CLI = 6'd30, OP_CLV = 6'd31,
    OP_SEC = 6'd32, OP_SED = 6'd33, OP_SEI = 6'd34, OP_BCC = 6'd35,
    OP_BCS = 6'd36, OP_BEQ = 6'd37, OP_BNE = 6'd38, OP_BMI = 6'd39,
    OP_BPL = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42, OP_JMP = 6'd43,
    OP_STA = 6'd44, OP_STX = 6'd45, OP_STY = 6'd46, OP_NOP = 6'd47
  } op_e;

  typedef enum logic [2:0] {
    CLS_ALU, CLS_RMW, CLS_REG, CLS_FLAG, CLS_BRANCH, CLS_JUMP, CLS_STORE, CLS_NONE
  } op_class_e;

  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0]  FLAGS_RESET = 8'h04;
  localparam logic [7:0]  SP_RESET    = 8'hFF;
  localparam logic [15:0] PAGE_MASK   = 16'hFF00;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [7:0]  operand;
    logic [15:0] instr_address;
    logic [15:0] jump_target;
  } req_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  flags_out;
    logic [7:0]  mem_value;
    logic        mem_write;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
  } rsp_t;

  // A decoded operation as it travels from the front end to the back end.
  typedef struct packed {
    op_e         op;
    op_class_e   cls;
    logic [7:0]  operand;
    logic [15:0] instr_address;
    logic [15:0] jump_target;
  } dec_t;

endpackage

[sv/cpu8_front.sv]
// Front end: accepts requests, classifies them and queues them for execution.
module cpu8_front import cpu8_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic dec_valid_o,
  input  logic dec_ready_i,
  output dec_t dec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  dec_t           fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  dec_t           dec_d;
  logic           push, pop;

  always_comb begin
    dec_d.operand       = req_i.operand;
    dec_d.instr_address = req_i.instr_address;
    dec_d.jump_target   = req_i.jump_target;
    // Codes above the defined set behave as a no-operation.
    dec_d.op = (req_i.req_type > 6'd47) ? OP_NOP : op_e'(req_i.req_type);
    case (dec_d.op) inside
      [OP_ADC:OP_LDY], [OP_INX:OP_TXS]: dec_d.cls = CLS_REG;
      [OP_ASL:OP_DEC]:                  dec_d.cls = CLS_RMW;
      [OP_CLC:OP_SEI]:                  dec_d.cls = CLS_FLAG;
      [OP_BCC:OP_BVS]:                  dec_d.cls = CLS_BRANCH;
      OP_JMP:                           dec_d.cls = CLS_JUMP;
      [OP_STA:OP_STY]:                  dec_d.cls = CLS_STORE;
      default:                          dec_d.cls = CLS_NONE;
    endcase
  end

  assign req_ready_o = (count_q != (PtrW+1)'(Depth));
  assign dec_valid_o = (count_q != '0);
  assign dec_o       = fifo_q[rd_ptr_q];
  assign push        = req_valid_i && req_ready_o;
  assign pop         = dec_valid_o && dec_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

[sv/cpu8_back.sv]
// Back end: executes decoded operations, holds the registers and the result.
module cpu8_back import cpu8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic dec_valid_i,
  output logic dec_ready_o,
  input  dec_t dec_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic [7:0] a_q, x_q, y_q, p_q, sp_q;
  logic [7:0] a_d, x_d, y_d, p_d, sp_d;
  logic       rsp_valid_q;
  rsp_t       rsp_q, rsp_d;
  logic       fire;

  assign dec_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = dec_valid_i && dec_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    logic [7:0] m, r;
    logic [8:0] bin, diff;
    logic [4:0] lo, hi;
    logic [5:0] dlo, dhi;
    logic       c, brw, take;
    logic [15:0] tgt;

    m    = dec_i.operand;
    c    = p_q[FL_C];
    a_d  = a_q;
    x_d  = x_q;
    y_d  = y_q;
    p_d  = p_q;
    sp_d = sp_q;
    r    = '0;
    take = 1'b0;
    bin  = '0;
    diff = '0;
    lo   = '0;
    hi   = '0;
    dlo  = '0;
    dhi  = '0;
    brw  = 1'b0;
    rsp_d.mem_value    = '0;
    rsp_d.mem_write    = 1'b0;
    rsp_d.next_pc      = dec_i.instr_address;
    rsp_d.extra_cycles = 2'd0;

    case (dec_i.op)
      OP_ADC: begin
        bin = {1'b0, a_q} + {1'b0, m} + {8'd0, c};
        if (p_q[FL_D]) begin
          // Digit sums can exceed five bits once the +6 adjust is added.
          dlo = {2'b0, a_q[3:0]} + {2'b0, m[3:0]} + {5'd0, c};
          if (dlo > 6'd9) dlo = dlo + 6'd6;
          dhi = {2'b0, a_q[7:4]} + {2'b0, m[7:4]} + {5'd0, (dlo > 6'd15)};
          p_d[FL_Z] = (bin[7:0] == 8'd0);
          p_d[FL_N] = dhi[3];
          p_d[FL_V] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ dhi[3]);
          if (dhi > 6'd9) dhi = dhi + 6'd6;
          p_d[FL_C] = (dhi > 6'd15);
          a_d = {dhi[3:0], dlo[3:0]};
        end else begin
          p_d[FL_N] = bin[7];
          p_d[FL_Z] = (bin[7:0] == 8'd0);
          p_d[FL_V] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ bin[7]);
          p_d[FL_C] = bin[8];
          a_d = bin[7:0];
        end
      end
      OP_SBC: begin
        diff = {1'b0, a_q} - {1'b0, m} - {8'd0, ~c};
        p_d[FL_N] = diff[7];
        p_d[FL_Z] = (diff[7:0] == 8'd0);
        p_d[FL_V] = (a_q[7] ^ m[7]) & (a_q[7] ^ diff[7]);
        p_d[FL_C] = ~diff[8];
        if (p_q[FL_D]) begin
          lo  = {1'b0, a_q[3:0]} - {1'b0, m[3:0]} - {4'd0, ~c};
          brw = lo[4];
          if (brw) lo = lo - 5'd6;
          hi = {1'b0, a_q[7:4]} - {1'b0, m[7:4]} - {4'd0, brw};
          if (hi[4]) hi = hi - 5'd6;
          a_d = {hi[3:0], lo[3:0]};
        end else begin
          a_d = diff[7:0];
        end
      end
      OP_AND: begin a_d = a_q & m; r = a_d; end
      OP_ORA: begin a_d = a_q | m; r = a_d; end
      OP_EOR: begin a_d = a_q ^ m; r = a_d; end
      OP_CMP, OP_CPX, OP_CPY: begin
        r = (dec_i.op == OP_CMP) ? a_q : ((dec_i.op == OP_CPX) ? x_q : y_q);
        diff = {1'b0, r} - {1'b0, m};
        p_d[FL_C] = ~diff[8];
        r = diff[7:0];
      end
      OP_BIT: begin
        p_d[FL_Z] = ((a_q & m) == 8'd0);
        p_d[FL_N] = m[7];
        p_d[FL_V] = m[6];
      end
      OP_LDA: begin a_d = m; r = m; end
      OP_LDX: begin x_d = m; r = m; end
      OP_LDY: begin y_d = m; r = m; end
      OP_ASL: begin r = {m[6:0], 1'b0}; p_d[FL_C] = m[7]; end
      OP_LSR: begin r = {1'b0, m[7:1]}; p_d[FL_C] = m[0]; end
      OP_ROL: begin r = {m[6:0], c};    p_d[FL_C] = m[7]; end
      OP_ROR: begin r = {c, m[7:1]};    p_d[FL_C] = m[0]; end
      OP_INC: r = m + 8'd1;
      OP_DEC: r = m - 8'd1;
      OP_INX: begin x_d = x_q + 8'd1; r = x_d; end
      OP_INY: begin y_d = y_q + 8'd1; r = y_d; end
      OP_DEX: begin x_d = x_q - 8'd1; r = x_d; end
      OP_DEY: begin y_d = y_q - 8'd1; r = y_d; end
      OP_TAX: begin x_d = a_q; r = a_q; end
      OP_TAY: begin y_d = a_q; r = a_q; end
      OP_TXA: begin a_d = x_q; r = x_q; end
      OP_TYA: begin a_d = y_q; r = y_q; end
      OP_TSX: begin x_d = sp_q; r = sp_q; end
      OP_TXS: sp_d = x_q;
      OP_CLC: p_d[FL_C] = 1'b0;
      OP_CLD: p_d[FL_D] = 1'b0;
      OP_CLI: p_d[FL_I] = 1'b0;
      OP_CLV: p_d[FL_V] = 1'b0;
      OP_SEC: p_d[FL_C] = 1'b1;
      OP_SED: p_d[FL_D] = 1'b1;
      OP_SEI: p_d[FL_I] = 1'b1;
      OP_BCC: take = ~p_q[FL_C];
      OP_BCS: take = p_q[FL_C];
      OP_BEQ: take = p_q[FL_Z];
      OP_BNE: take = ~p_q[FL_Z];
      OP_BMI: take = p_q[FL_N];
      OP_BPL: take = ~p_q[FL_N];
      OP_BVC: take = ~p_q[FL_V];
      OP_BVS: take = p_q[FL_V];
      OP_JMP: rsp_d.next_pc = dec_i.jump_target;
      OP_STA: begin rsp_d.mem_value = a_q; rsp_d.mem_write = 1'b1; end
      OP_STX: begin rsp_d.mem_value = x_q; rsp_d.mem_write = 1'b1; end
      OP_STY: begin rsp_d.mem_value = y_q; rsp_d.mem_write = 1'b1; end
      default: ;
    endcase

    // Logic, loads, compares, shifts, rotates, increments, decrements and transfers other than TXS set N and Z from r.
    if (dec_i.cls == CLS_RMW ||
        (dec_i.cls == CLS_REG && dec_i.op != OP_ADC && dec_i.op != OP_SBC &&
         dec_i.op != OP_BIT && dec_i.op != OP_TXS)) begin
      p_d[FL_N] = r[7];
      p_d[FL_Z] = (r == 8'd0);
    end
    if (dec_i.cls == CLS_RMW) begin
      rsp_d.mem_value = r;
      rsp_d.mem_write = 1'b1;
    end

    tgt = dec_i.instr_address + {{8{m[7]}}, m};
    if (dec_i.cls == CLS_BRANCH && take) begin
      rsp_d.next_pc = tgt;
      rsp_d.extra_cycles =
        ((tgt & PAGE_MASK) != (dec_i.instr_address & PAGE_MASK)) ? 2'd2 : 2'd1;
    end

    rsp_d.acc_out   = a_d;
    rsp_d.x_out     = x_d;
    rsp_d.y_out     = y_d;
    rsp_d.flags_out = p_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      p_q         <= FLAGS_RESET;
      sp_q        <= SP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        a_q  <= a_d;
        x_q  <= x_d;
        y_q  <= y_d;
        p_q  <= p_d;
        sp_q <= sp_d;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

endmodule

[sv/cpu8_alu_register_execute_unit.sv]
// Top level of the 8-bit execute unit: request queue plus execution stage.
// Requests arrive on req_valid_i/req_ready_o with a req_t beat holding the
// operation code, operand byte, instruction address and jump target. Each
// request yields exactly one rsp_t beat on rsp_valid_o/rsp_ready_i with the
// registers, flags, memory write-back byte and strobe, next PC and the
// branch penalty cycles.
// A beat enters a small queue on acceptance and is executed when it reaches
// the head; it passes through the queue register and then the result
// register before it appears on rsp_o. One beat per cycle is sustained while
// the receiver keeps rsp_ready_i high: the execution stage computes A, X, Y,
// P and S combinationally from their registers, and its result register is
// reloaded in the same cycle it is read out.
// Reset clears A, X and Y, sets the flags to the interrupt mask alone, sets
// the stack pointer to 0xFF and empties the queue and result register.
// When the receiver stalls the result holds; the queue then fills and
// req_ready_o drops once QueueDepth beats are waiting.
module cpu8_alu_register_execute_unit import cpu8_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic dec_valid, dec_ready;
  dec_t dec;

  cpu8_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_o, .req_i,
    .dec_valid_o(dec_valid), .dec_ready_i(dec_ready), .dec_o(dec)
  );

  cpu8_back u_back (
    .clk_i, .rst_ni,
    .dec_valid_i(dec_valid), .dec_ready_o(dec_ready), .dec_i(dec),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

endmodule

[sim/cpu8_alu_register_execute_unit_tb.sv]
// Self-checking testbench for the 8-bit ALU and register execute unit.
module cpu8_alu_register_execute_unit_tb;
  import cpu8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomOps = 1700;
  localparam int unsigned WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  cpu8_alu_register_execute_unit dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted architectural state.
  logic [7:0] acc_q, x_q, y_q, p_q, sp_q;
  rsp_t exp_rsp_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  // Directed stimulus; chk marks rows whose result is typed in.
  typedef struct {
    req_t req;
    bit   chk;
    rsp_t rsp;
  } dir_row_t;

  function automatic void set_nz(input logic [7:0] v);
    p_q[FL_N] = v[7];
    p_q[FL_Z] = (v == 8'h00);
  endfunction

  function automatic rsp_t execute_op(input req_t r);
    rsp_t o;
    logic [8:0] bin, sum9;
    logic [4:0] lo, hi;
    logic [5:0] alo, ahi;
    logic [7:0] m, res;
    logic [15:0] tgt;
    logic cin, brw, dbrw, take;
    m = r.operand;
    o = '0;
    o.next_pc = r.instr_address;
    take = 1'b0;
    cin = p_q[FL_C];
    case (r.req_type)
      OP_ADC: begin
        sum9 = {1'b0, acc_q} + {1'b0, m} + cin;
        if (p_q[FL_D]) begin
          alo = {2'b0, acc_q[3:0]} + {2'b0, m[3:0]} + {5'd0, cin};
          if (alo > 6'd9) alo = alo + 6'd6;
          ahi = {2'b0, acc_q[7:4]} + {2'b0, m[7:4]} + {5'd0, (alo > 6'd15)};
          p_q[FL_Z] = (sum9[7:0] == 8'h00);
          p_q[FL_N] = ahi[3];
          p_q[FL_V] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ ahi[3]);
          if (ahi > 6'd9) ahi = ahi + 6'd6;
          p_q[FL_C] = (ahi > 6'd15);
          acc_q = {ahi[3:0], alo[3:0]};
        end else begin
          set_nz(sum9[7:0]);
          p_q[FL_V] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ sum9[7]);
          p_q[FL_C] = sum9[8];
          acc_q = sum9[7:0];
        end
      end
      OP_SBC: begin
        brw = ~cin;
        bin = {1'b0, acc_q} - {1'b0, m} - brw;
        set_nz(bin[7:0]);
        p_q[FL_V] = (acc_q[7] ^ m[7]) & (acc_q[7] ^ bin[7]);
        p_q[FL_C] = ({1'b0, acc_q} >= {1'b0, m} + brw);
        if (p_q[FL_D]) begin
          lo = {1'b0, acc_q[3:0]} - {1'b0, m[3:0]} - brw;
          dbrw = lo[4];
          if (dbrw) lo = lo - 5'd6;
          hi = {1'b0, acc_q[7:4]} - {1'b0, m[7:4]} - {4'd0, dbrw};
          if (hi[4]) hi = hi - 5'd6;
          acc_q = {hi[3:0], lo[3:0]};
        end else begin
          acc_q = bin[7:0];
        end
      end
      OP_AND: begin acc_q = acc_q & m; set_nz(acc_q); end
      OP_ORA: begin acc_q = acc_q | m; set_nz(acc_q); end
      OP_EOR: begin acc_q = acc_q ^ m; set_nz(acc_q); end
      OP_CMP: begin p_q[FL_C] = acc_q >= m; set_nz(acc_q - m); end
      OP_CPX: begin p_q[FL_C] = x_q >= m; set_nz(x_q - m); end
      OP_CPY: begin p_q[FL_C] = y_q >= m; set_nz(y_q - m); end
      OP_BIT: begin
        p_q[FL_Z] = ((acc_q & m) == 8'h00);
        p_q[FL_N] = m[7];
        p_q[FL_V] = m[6];
      end
      OP_LDA: begin acc_q = m; set_nz(m); end
      OP_LDX: begin x_q = m; set_nz(m); end
      OP_LDY: begin y_q = m; set_nz(m); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
        case (r.req_type)
          OP_ASL: begin res = {m[6:0], 1'b0}; p_q[FL_C] = m[7]; end
          OP_LSR: begin res = {1'b0, m[7:1]}; p_q[FL_C] = m[0]; end
          OP_ROL: begin res = {m[6:0], cin}; p_q[FL_C] = m[7]; end
          OP_ROR: begin res = {cin, m[7:1]}; p_q[FL_C] = m[0]; end
          OP_INC: res = m + 8'd1;
          default: res = m - 8'd1;
        endcase
        set_nz(res);
        o.mem_value = res;
        o.mem_write = 1'b1;
      end
      OP_INX: begin x_q = x_q + 8'd1; set_nz(x_q); end
      OP_INY: begin y_q = y_q + 8'd1; set_nz(y_q); end
      OP_DEX: begin x_q = x_q - 8'd1; set_nz(x_q); end
      OP_DEY: begin y_q = y_q - 8'd1; set_nz(y_q); end
      OP_TAX: begin x_q = acc_q; set_nz(x_q); end
      OP_TAY: begin y_q = acc_q; set_nz(y_q); end
      OP_TXA: begin acc_q = x_q; set_nz(acc_q); end
      OP_TYA: begin acc_q = y_q; set_nz(acc_q); end
      OP_TSX: begin x_q = sp_q; set_nz(x_q); end
      OP_TXS: sp_q = x_q;
      OP_CLC: p_q[FL_C] = 1'b0;
      OP_CLD: p_q[FL_D] = 1'b0;
      OP_CLI: p_q[FL_I] = 1'b0;
      OP_CLV: p_q[FL_V] = 1'b0;
      OP_SEC: p_q[FL_C] = 1'b1;
      OP_SED: p_q[FL_D] = 1'b1;
      OP_SEI: p_q[FL_I] = 1'b1;
      OP_BCC: take = ~p_q[FL_C];
      OP_BCS: take = p_q[FL_C];
      OP_BEQ: take = p_q[FL_Z];
      OP_BNE: take = ~p_q[FL_Z];
      OP_BMI: take = p_q[FL_N];
      OP_BPL: take = ~p_q[FL_N];
      OP_BVC: take = ~p_q[FL_V];
      OP_BVS: take = p_q[FL_V];
      OP_JMP: o.next_pc = r.jump_target;
      OP_STA: begin o.mem_value = acc_q; o.mem_write = 1'b1; end
      OP_STX: begin o.mem_value = x_q; o.mem_write = 1'b1; end
      OP_STY: begin o.mem_value = y_q; o.mem_write = 1'b1; end
      default: ;
    endcase
    if (take) begin
      tgt = r.instr_address + {{8{m[7]}}, m};
      o.next_pc = tgt;
      o.extra_cycles = ((tgt & PAGE_MASK) != (r.instr_address & PAGE_MASK)) ? 2'd2 : 2'd1;
    end
    o.acc_out = acc_q;
    o.x_out = x_q;
    o.y_out = y_q;
    o.flags_out = p_q;
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Mostly uniform over the defined codes, plus extra SED and CLD and some undefined codes.
  function automatic req_t random_req();
    req_t r;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 4) r.req_type = 6'($urandom_range(48, 63));
    else if (k < 12) r.req_type = OP_SED;
    else if (k < 20) r.req_type = OP_CLD;
    else r.req_type = 6'($urandom_range(0, 47));
    r.operand = 8'($urandom);
    r.instr_address = 16'($urandom);
    r.jump_target = 16'($urandom);
    if ($urandom_range(0, 3) == 0) r.instr_address[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return r;
  endfunction

  // Valid stays high into a back-to-back beat and drops only for a gap.
  task automatic send_beat(input req_t r);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      req_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    exp_rsp_q.push_back(execute_op(r));
  endtask

  function automatic req_t mk(input op_e op, input logic [7:0] m,
                              input logic [15:0] pc, input logic [15:0] jt);
    req_t r;
    r.req_type = op;
    r.operand = m;
    r.instr_address = pc;
    r.jump_target = jt;
    return r;
  endfunction

  function automatic rsp_t mkr(input logic [7:0] a, input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] p, input logic [7:0] mv, input logic mw,
                               input logic [15:0] pc, input logic [1:0] ex);
    rsp_t o;
    o.acc_out = a; o.x_out = x; o.y_out = y; o.flags_out = p;
    o.mem_value = mv; o.mem_write = mw; o.next_pc = pc; o.extra_cycles = ex;
    return o;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    acc_q = 8'h00; x_q = 8'h00; y_q = 8'h00; p_q = FLAGS_RESET; sp_q = SP_RESET;
    // After reset: NOP leaves everything at reset values.
    rows.push_back('{mk(OP_NOP, 8'hFF, 16'h1234, 16'hFFFF), 1'b1,
                     mkr(8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 1'b0, 16'h1234, 2'd0)});
    rows.push_back('{mk(OP_TSX, 8'h00, 16'h0000, 16'h0000), 1'b1,
                     mkr(8'h00, 8'hFF, 8'h00, 8'h84, 8'h00, 1'b0, 16'h0000, 2'd0)});
    rows.push_back('{mk(OP_LDA, 8'hFF, 16'hFFFF, 16'h0000), 1'b1,
                     mkr(8'hFF, 8'hFF, 8'h00, 8'h84, 8'h00, 1'b0, 16'hFFFF, 2'd0)});
    // Taken branch crossing a page backward, wrapping below zero.
    rows.push_back('{mk(OP_BMI, 8'h80, 16'h0010, 16'h0000), 1'b1,
                     mkr(8'hFF, 8'hFF, 8'h00, 8'h84, 8'h00, 1'b0, 16'hFF90, 2'd2)});
    rows.push_back('{mk(OP_ADC, 8'h01, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_BCS, 8'h7F, 16'hFF80, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_SED, 8'h00, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_LDA, 8'h99, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_ADC, 8'h01, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_LDA, 8'hFA, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_ADC, 8'hFF, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_SBC, 8'h99, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_SBC, 8'hAF, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_CLD, 8'h00, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_ROR, 8'h01, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_ROL, 8'h80, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_BIT, 8'hC0, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_BVS, 8'h00, 16'h00FF, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_TYA, 8'h00, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_DEY, 8'h00, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_STY, 8'h00, 16'h0000, 16'h0000), 1'b0, '0});
    rows.push_back('{mk(OP_JMP, 8'h00, 16'h0000, 16'hFFFF), 1'b0, '0});
    rows.push_back('{mk(op_e'(6'd63), 8'h55, 16'hAAAA, 16'h5555), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.req);
      if (row.chk) exp_rsp_q[$] = row.rsp;
    end
    for (int i = 0; i < 32; i++) send_beat(mk(OP_INY, 8'h00, 16'h0000, 16'h0000));
    hold_off = 1'b1;
    for (int unsigned i = 0; i < RandomOps; i++) send_beat(random_req());
    req_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off to back-pressure the queue.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        rsp_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      g = gap_len();
      if (g != 0 && $urandom_range(0, 1)) begin
        rsp_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (exp_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", rsp_o);
      end else begin
        e = exp_rsp_q.pop_front();
        if (rsp_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp a=%h x=%h y=%h p=%h mv=%h mw=%b pc=%h ex=%0d",
                     e.acc_out, e.x_out, e.y_out, e.flags_out, e.mem_value,
                     e.mem_write, e.next_pc, e.extra_cycles,
                     "\n          got a=%h x=%h y=%h p=%h mv=%h mw=%b pc=%h ex=%0d",
                     rsp_o.acc_out, rsp_o.x_out, rsp_o.y_out, rsp_o.flags_out,
                     rsp_o.mem_value, rsp_o.mem_write, rsp_o.next_pc, rsp_o.extra_cycles);
        end
      end
    end
  end

  // Watchdog on cycles without any beat, and end-of-run check.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && exp_rsp_q.size() == 0) begin
        repeat (10) @(posedge clk_i);
        if (mismatches == 0 && !rsp_valid_o) $display("cpu8_alu_register_execute_unit_tb: clean");
        else $display("cpu8_alu_register_execute_unit_tb: errors");
        $finish;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("cpu8_alu_register_execute_unit_tb: errors");
        $finish;
      end
    end
  end

endmodule

[files.f]
sv/cpu8_pkg.sv
sv/cpu8_front.sv
sv/cpu8_back.sv
sv/cpu8_alu_register_execute_unit.sv
sim/cpu8_alu_register_execute_unit_tb.sv
